FILE: sv/pab_pkg.sv
// Shared constants, types and widths for the palette alpha-over blender.
// Used by the front, queue, back and top-level modules.
package pab_pkg;

  localparam int PALETTE_COUNT       = 8;
  localparam int ENTRIES_PER_PALETTE = 256;
  localparam int STORE_DEPTH         = PALETTE_COUNT * ENTRIES_PER_PALETTE;
  localparam int STORE_AW            = $clog2(STORE_DEPTH);
  localparam int FIFO_DEPTH          = 4;
  localparam int FIFO_AW             = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW             = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_STAGES          = 9;
  localparam int REM_W               = 26;
  localparam logic [24:0] RECIP_255  = 25'd16843010;
  localparam logic [7:0] ALPHA_MAX   = 8'd255;
  localparam logic [7:0] ROUND_255   = 8'd127;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  typedef struct packed {
    rgba_t src;
    rgba_t dst;
  } blend_item_t;

endpackage

FILE: sv/pab_front.sv
// Front part: accepts items, stores palette entries, looks up blend sources.
// Depends on pab_pkg; feeds pab_fifo.
module pab_front import pab_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [79:0]          s_axis_tdata_i,
  input  logic                 s_axis_tuser_i,
  input  logic [2:0]           active_palette_i,
  input  logic [FIFO_CW-1:0]   fifo_cnt_i,
  output logic                 push_o,
  output blend_item_t          push_data_o
);

  logic [31:0] store_q [STORE_DEPTH];
  logic [31:0] rd_q;
  logic        s1_v_q;
  logic        ok_q;
  rgba_t       dst_q;
  logic        acc;
  logic [2:0]  pal;
  logic [7:0]  idx;
  logic        wr_ok;
  logic        rd_ok;
  logic [STORE_AW-1:0] wr_addr;
  logic [STORE_AW-1:0] rd_addr;

  assign pal = s_axis_tdata_i[2:0];
  assign idx = s_axis_tdata_i[10:3];
  assign s_axis_tready_o = (32'(fifo_cnt_i) + 32'(s1_v_q)) < FIFO_DEPTH;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_ok = (32'(pal) < PALETTE_COUNT) && (32'(idx) < ENTRIES_PER_PALETTE);
  assign rd_ok = (32'(active_palette_i) < PALETTE_COUNT) &&
                 (32'(idx) < ENTRIES_PER_PALETTE);
  assign wr_addr = STORE_AW'(32'(pal) * ENTRIES_PER_PALETTE + 32'(idx));
  assign rd_addr = STORE_AW'(32'(active_palette_i) * ENTRIES_PER_PALETTE + 32'(idx));

  always_ff @(posedge clk_i) begin
    if (acc && !s_axis_tuser_i && wr_ok) begin
      store_q[wr_addr] <= {s_axis_tdata_i[18:11], s_axis_tdata_i[26:19],
                           s_axis_tdata_i[34:27], s_axis_tdata_i[42:35]};
    end
    if (acc && s_axis_tuser_i) begin
      rd_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && s_axis_tuser_i) begin
      ok_q  <= rd_ok;
      dst_q <= {s_axis_tdata_i[50:43], s_axis_tdata_i[58:51],
                s_axis_tdata_i[66:59], s_axis_tdata_i[74:67]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= acc && s_axis_tuser_i;
    end
  end

  assign push_o = s1_v_q;
  assign push_data_o.src = ok_q ? rd_q : '0;
  assign push_data_o.dst = dst_q;

endmodule

FILE: sv/pab_fifo.sv
// Short queue of looked-up blend items between front and back parts.
// Depends on pab_pkg.
module pab_fifo import pab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  blend_item_t        push_data_i,
  input  logic               pop_i,
  output blend_item_t        head_o,
  output logic               empty_o,
  output logic [FIFO_CW-1:0] cnt_o
);

  blend_item_t        mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q;
  logic [FIFO_AW-1:0] rp_q;
  logic [FIFO_CW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (32'(wp_q) == FIFO_DEPTH - 1) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (32'(rp_q) == FIFO_DEPTH - 1) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + FIFO_CW'(push_i) - FIFO_CW'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> 32'(cnt_q) < FIFO_DEPTH) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= FIFO_DEPTH) else $error("queue count out of range");

endmodule

FILE: sv/pab_back.sv
// Back part: pipelined alpha-over compositing with a restoring divider.
// Depends on pab_pkg; reads items from pab_fifo.
module pab_back import pab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  blend_item_t head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o
);

  typedef struct packed {
    rgba_t       src;
    rgba_t       dst;
    logic        pass;
    logic        solid;
    logic [7:0]  inv;
    logic [16:0] x;
  } st0_t;

  typedef struct packed {
    rgba_t            src;
    rgba_t            dst;
    logic             pass;
    logic             solid;
    logic [7:0]       inv;
    logic [41:0]      prod;
    logic [2:0][15:0] ps;
    logic [2:0][15:0] pd;
  } st1_t;

  typedef struct packed {
    rgba_t            src;
    rgba_t            dst;
    logic             pass;
    logic             solid;
    logic [7:0]       oa;
    logic [15:0]      den;
    logic [2:0][23:0] ns;
    logic [2:0][23:0] nd;
  } st2_t;

  typedef struct packed {
    rgba_t                 src;
    rgba_t                 dst;
    logic                  pass;
    logic                  solid;
    logic [7:0]            oa;
    logic [15:0]           den;
    logic [2:0][REM_W-1:0] r;
    logic [2:0][8:0]       q;
  } div_t;

  function automatic logic [7:0] chan(input rgba_t p, input int c);
    logic [7:0] v;
    case (c)
      0:       v = p.r;
      1:       v = p.g;
      default: v = p.b;
    endcase
    return v;
  endfunction

  logic en;
  logic v0_q, v1_q, v2_q;
  logic [DIV_STAGES:0] dv_q;
  st0_t s0_d, s0_q;
  st1_t s1_d, s1_q;
  st2_t s2_d, s2_q;
  div_t dd [DIV_STAGES+1];
  div_t dq [DIV_STAGES+1];
  logic        m_valid_q;
  logic [31:0] m_data_q;
  logic [31:0] res;

  assign en    = !m_valid_q || m_axis_tready_i;
  assign pop_o = en && !empty_i;

  always_comb begin
    s0_d.src   = head_i.src;
    s0_d.dst   = head_i.dst;
    s0_d.pass  = (head_i.src.a == '0);
    s0_d.solid = (head_i.src.a == ALPHA_MAX) || (head_i.dst.a == '0);
    s0_d.inv   = ALPHA_MAX - head_i.src.a;
    s0_d.x     = 17'(head_i.dst.a) * 17'(s0_d.inv) + 17'(ROUND_255);
  end

  always_comb begin
    s1_d.src   = s0_q.src;
    s1_d.dst   = s0_q.dst;
    s1_d.pass  = s0_q.pass;
    s1_d.solid = s0_q.solid;
    s1_d.inv   = s0_q.inv;
    s1_d.prod  = 42'(s0_q.x) * 42'(RECIP_255);
    for (int c = 0; c < 3; c++) begin
      s1_d.ps[c] = 16'(chan(s0_q.src, c)) * 16'(s0_q.src.a);
      s1_d.pd[c] = 16'(chan(s0_q.dst, c)) * 16'(s0_q.dst.a);
    end
  end

  always_comb begin
    s2_d.src   = s1_q.src;
    s2_d.dst   = s1_q.dst;
    s2_d.pass  = s1_q.pass;
    s2_d.solid = s1_q.solid;
    s2_d.oa    = s1_q.src.a + s1_q.prod[39:32];
    s2_d.den   = {s2_d.oa, 8'd0} - 16'(s2_d.oa);
    for (int c = 0; c < 3; c++) begin
      s2_d.ns[c] = {s1_q.ps[c], 8'd0} - 24'(s1_q.ps[c]);
      s2_d.nd[c] = 24'(s1_q.pd[c]) * 24'(s1_q.inv);
    end
  end

  always_comb begin
    dd[0].src   = s2_q.src;
    dd[0].dst   = s2_q.dst;
    dd[0].pass  = s2_q.pass;
    dd[0].solid = s2_q.solid;
    dd[0].oa    = s2_q.oa;
    dd[0].den   = s2_q.den;
    dd[0].q     = '0;
    for (int c = 0; c < 3; c++) begin
      dd[0].r[c] = REM_W'(s2_q.ns[c]) + REM_W'(s2_q.nd[c]) + REM_W'(s2_q.den >> 1);
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    always_comb begin
      logic [REM_W-1:0] sh;
      dd[k] = dq[k-1];
      sh = REM_W'(dq[k-1].den) << (DIV_STAGES - k);
      for (int c = 0; c < 3; c++) begin
        if (dq[k-1].r[c] >= sh) begin
          dd[k].r[c] = dq[k-1].r[c] - sh;
          dd[k].q[c][DIV_STAGES-k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res = {dq[DIV_STAGES].src.r, dq[DIV_STAGES].src.g,
           dq[DIV_STAGES].src.b, dq[DIV_STAGES].src.a};
    if (dq[DIV_STAGES].pass) begin
      res = {dq[DIV_STAGES].dst.r, dq[DIV_STAGES].dst.g,
             dq[DIV_STAGES].dst.b, dq[DIV_STAGES].dst.a};
    end else if (!dq[DIV_STAGES].solid) begin
      for (int c = 0; c < 3; c++) begin
        res[31-8*c -: 8] = dq[DIV_STAGES].q[c][8] ? ALPHA_MAX : dq[DIV_STAGES].q[c][7:0];
      end
      res[7:0] = dq[DIV_STAGES].oa;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s0_d;
      s1_q <= s1_d;
      s2_q <= s2_d;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        dq[k] <= dd[k];
      end
      if (dv_q[DIV_STAGES]) begin
        m_data_q <= {res[7:0], res[15:8], res[23:16], res[31:24]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      dv_q      <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      v0_q      <= pop_o;
      v1_q      <= v0_q;
      v2_q      <= v1_q;
      dv_q      <= {dv_q[DIV_STAGES-1:0], v2_q};
      m_valid_q <= dv_q[DIV_STAGES];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_q) && $stable(v0_q)) else $error("pipeline moved while stalled");
  a_pop_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> en) else $error("item taken while stalled");
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && dv_q[DIV_STAGES] |=> m_valid_q) else $error("result lost");

endmodule

FILE: sv/palette_alpha_over_blender_unit.sv
// Top level of the palette alpha-over blender: front, queue and back parts.
// Depends on pab_pkg, pab_front, pab_fifo and pab_back.
//
// Usage: items arrive on the s_axis channel. tuser low writes one palette
// entry (no result); tuser high blends one destination pixel with the entry
// looked up in the active palette and yields one result on m_axis.
// The cfg channel sets the active palette; it is always ready and must be
// written only while the block is idle.
// A blend item passes, in order, through the store read at acceptance,
// the queue, four arithmetic stages, nine divider stages and the output
// register. Throughput: one item per cycle while the receiver is ready,
// set by the one-bit-per-stage divider pipeline and the single store port;
// writes and blends may interleave. When the receiver stalls, the back
// pipeline holds in place and the queue fills; s_axis_tready_o drops once
// queued and in-flight items reach the queue depth.
// Reset clears the active palette to 0 and empties the pipeline; palette
// entries are undefined until written.
module palette_alpha_over_blender_unit import pab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // palette_number, colour_index, entry r,g,b,a, dest r,g,b,a, zero pad
  input  logic [79:0] s_axis_tdata_i,
  // mode
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i
);

  logic [2:0]         active_q;
  logic               push;
  blend_item_t        push_data;
  logic               pop;
  blend_item_t        head;
  logic               empty;
  logic [FIFO_CW-1:0] cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  pab_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .s_axis_tuser_i, .active_palette_i(active_q), .fifo_cnt_i(cnt),
    .push_o(push), .push_data_o(push_data)
  );

  pab_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .pop_i(pop),
    .head_o(head), .empty_o(empty), .cnt_o(cnt)
  );

  pab_back u_back (
    .clk_i, .rst_ni, .head_i(head), .empty_i(empty), .pop_o(pop),
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

endmodule
